### rtl/core/rcsg_pkg.sv
// ----------------------------------------------------------------------------
// rcsg_pkg
// Shared widths, opcodes and register indexes of the RGB channel shift block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsg_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int POS_W      = 7;   // pixel column or row in an item
  localparam int DIM_W      = 8;   // frame width or height register
  localparam int OFS_W      = 9;   // signed shift register
  localparam int COORD_W    = 10;  // signed displaced coordinate
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int FRAME_DIM_RST = 128;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 2'd3;

endpackage

`default_nettype wire

### rtl/core/rcsg_if.sv
// ----------------------------------------------------------------------------
// rcsg_in_if / rcsg_out_if
// Valid/ready channels carrying pixel commands in and shifted pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsg_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [rcsg_pkg::POS_W-1:0] pos_x;
  logic [rcsg_pkg::POS_W-1:0] pos_y;
  logic [rcsg_pkg::CH_W-1:0]  red_in;
  logic [rcsg_pkg::CH_W-1:0]  green_in;
  logic [rcsg_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface rcsg_out_if;
  logic                      valid;
  logic                      ready;
  logic [rcsg_pkg::CH_W-1:0] red_out;
  logic [rcsg_pkg::CH_W-1:0] green_out;
  logic [rcsg_pkg::CH_W-1:0] blue_out;
  logic                      in_frame;

  modport source (output valid, red_out, green_out, blue_out, in_frame, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, in_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/rgb_channel_shift_glitch.sv
// ----------------------------------------------------------------------------
// rgb_channel_shift_glitch
// Frame store with chromatic split read-out: red from the forward shifted
// pixel, blue from the backward shifted pixel, green from the addressed one.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      opcode, pos_x, pos_y, red_in..blue_in
//   out_ch   out  valid / ready      red_out, green_out, blue_out, in_frame
//   cfg_*    in   cfg_we (no wait)   cfg_index, cfg_wdata
//
// One item per cycle while in_ch.ready is high. A write lands in the store at
// its accepting edge; the registered read port of the three channel memories
// gives a read result in the cycle after acceptance. in_ch.ready drops only
// while a result waits and out_ch.ready is low. Reset (synchronous, rst_n low)
// clears output valid and offsets, presets the frame size, keeps the store.
//
// The store is kept as three copies, one per channel, each written with the
// same position. Each copy is read at its own address: red at the forward
// shifted position, blue at the backward one, green at the addressed pixel.
// A shifted position outside the frame falls back to the addressed pixel by
// steering that copy's address, so no mux is needed after the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_channel_shift_glitch #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rcsg_in_if.sink                              in_ch,
  rcsg_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [rcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcsg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RST_W = (MAX_WIDTH  < rcsg_pkg::FRAME_DIM_RST) ? MAX_WIDTH
                                                                : rcsg_pkg::FRAME_DIM_RST;
  localparam int RST_H = (MAX_HEIGHT < rcsg_pkg::FRAME_DIM_RST) ? MAX_HEIGHT
                                                                : rcsg_pkg::FRAME_DIM_RST;

  // Effective frame size: already clipped to the store on write.
  logic [rcsg_pkg::DIM_W-1:0]        eff_w_r, eff_h_r;
  logic signed [rcsg_pkg::OFS_W-1:0] ofs_x_r, ofs_y_r;

  logic [rcsg_pkg::DIM_W-1:0] cfg_dim;
  logic [rcsg_pkg::DIM_W-1:0] clip_w, clip_h;

  assign cfg_dim = cfg_wdata[rcsg_pkg::DIM_W-1:0];
  assign clip_w  = ({24'd0, cfg_dim} > 32'(MAX_WIDTH))  ? 8'(MAX_WIDTH)  : cfg_dim;
  assign clip_h  = ({24'd0, cfg_dim} > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : cfg_dim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= 8'(RST_W);
      eff_h_r <= 8'(RST_H);
      ofs_x_r <= '0;
      ofs_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcsg_pkg::REG_FRAME_WIDTH:  eff_w_r <= clip_w;
        rcsg_pkg::REG_FRAME_HEIGHT: eff_h_r <= clip_h;
        rcsg_pkg::REG_OFFSET_X:     ofs_x_r <= cfg_wdata;
        rcsg_pkg::REG_OFFSET_Y:     ofs_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: hold the input while a result waits on a stalled sink.
  logic valid_r, valid_nxt;
  logic in_fire, rd_fire, wr_fire;
  logic in_store;

  assign in_ch.ready = ~valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_store    = ({25'd0, in_ch.pos_x} < 32'(MAX_WIDTH)) &
                       ({25'd0, in_ch.pos_y} < 32'(MAX_HEIGHT));
  assign rd_fire     = in_fire & (in_ch.opcode == rcsg_pkg::OPC_READ);
  assign wr_fire     = in_fire & (in_ch.opcode == rcsg_pkg::OPC_WRITE) & in_store;
  assign valid_nxt   = rd_fire | (valid_r & ~out_ch.ready);

  // Displaced coordinates, 10-bit signed.
  logic [rcsg_pkg::COORD_W-1:0] px, py, ox, oy, rx, ry, bx, by;
  logic own_in, red_in_frame, blue_in_frame;

  assign px = {3'd0, in_ch.pos_x};
  assign py = {3'd0, in_ch.pos_y};
  assign ox = {ofs_x_r[rcsg_pkg::OFS_W-1], ofs_x_r};
  assign oy = {ofs_y_r[rcsg_pkg::OFS_W-1], ofs_y_r};
  assign rx = px + ox;
  assign ry = py + oy;
  assign bx = px - ox;
  assign by = py - oy;

  assign own_in        = (px[8:0] < {1'b0, eff_w_r}) & (py[8:0] < {1'b0, eff_h_r});
  assign red_in_frame  = ~rx[9] & ~ry[9] &
                         (rx[8:0] < {1'b0, eff_w_r}) & (ry[8:0] < {1'b0, eff_h_r});
  assign blue_in_frame = ~bx[9] & ~by[9] &
                         (bx[8:0] < {1'b0, eff_w_r}) & (by[8:0] < {1'b0, eff_h_r});

  // Fall back to the addressed pixel when a shifted position leaves the frame.
  logic [7:0]    red_col, red_row, blue_col, blue_row;
  logic [AW-1:0] own_addr, red_addr, blue_addr;

  assign red_col  = red_in_frame  ? rx[7:0] : px[7:0];
  assign red_row  = red_in_frame  ? ry[7:0] : py[7:0];
  assign blue_col = blue_in_frame ? bx[7:0] : px[7:0];
  assign blue_row = blue_in_frame ? by[7:0] : py[7:0];

  assign own_addr  = AW'(in_ch.pos_y) * AW'(MAX_WIDTH) + AW'(in_ch.pos_x);
  assign red_addr  = AW'(red_row)  * AW'(MAX_WIDTH) + AW'(red_col);
  assign blue_addr = AW'(blue_row) * AW'(MAX_WIDTH) + AW'(blue_col);

  // Channel stores, one write port and one registered read port each.
  logic [rcsg_pkg::CH_W-1:0] mem_red   [DEPTH];
  logic [rcsg_pkg::CH_W-1:0] mem_green [DEPTH];
  logic [rcsg_pkg::CH_W-1:0] mem_blue  [DEPTH];

  logic [rcsg_pkg::CH_W-1:0] red_q_r, green_q_r, blue_q_r;
  logic                      in_frame_r;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_red[own_addr]   <= in_ch.red_in;
      mem_green[own_addr] <= in_ch.green_in;
      mem_blue[own_addr]  <= in_ch.blue_in;
    end
    if (rd_fire) begin
      red_q_r    <= mem_red[red_addr];
      green_q_r  <= mem_green[own_addr];
      blue_q_r   <= mem_blue[blue_addr];
      in_frame_r <= own_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Drop the channels of a read outside the frame.
  assign out_ch.valid     = valid_r;
  assign out_ch.red_out   = in_frame_r ? red_q_r   : '0;
  assign out_ch.green_out = in_frame_r ? green_q_r : '0;
  assign out_ch.blue_out  = in_frame_r ? blue_q_r  : '0;
  assign out_ch.in_frame  = in_frame_r;

endmodule

`default_nettype wire

### rtl/core/rcsg_checker.sv
// ----------------------------------------------------------------------------
// rcsg_checker
// Port-level checks of the RGB channel shift block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsg_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_opcode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rcsg_pkg::CH_W-1:0] red_out,
  input logic [rcsg_pkg::CH_W-1:0] green_out,
  input logic [rcsg_pkg::CH_W-1:0] blue_out,
  input logic                      in_frame
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Every accepted read shows its result on the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == rcsg_pkg::OPC_READ |=> out_valid)
    else $error("read produced no result");

  // A write with no pending result leaves the output empty.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == rcsg_pkg::OPC_WRITE &&
    !(out_valid && !out_ready) |=> !out_valid)
    else $error("write produced a result");

  // Outside the frame every channel reads zero.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_frame |-> red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("nonzero channel outside the frame");

endmodule

bind rgb_channel_shift_glitch rcsg_checker u_rcsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red_out   (out_ch.red_out),
  .green_out (out_ch.green_out),
  .blue_out  (out_ch.blue_out),
  .in_frame  (out_ch.in_frame)
);

`default_nettype wire
